// File: hw/rtl/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared widths, kind codes and the pipeline control struct for the
// quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int COEF_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int VAL_WIDTH      = 36;

  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_REAL    = 2'd1;
  localparam logic [1:0] KIND_EQUAL   = 2'd2;
  localparam logic [1:0] KIND_COMPLEX = 2'd3;

  // Control that travels beside each item.
  typedef struct packed {
    logic       vld;
    logic [1:0] kind;
  } qrs_ctl_t;

endpackage

// File: hw/rtl/qrs_disc.sv
// ----------------------------------------------------------------------------
// qrs_disc
// Two-stage discriminant: products registered, then b*b - 4ac and the
// case decision. Emits |d|, -b scaled to fixed point and 2a.
// ----------------------------------------------------------------------------
module qrs_disc
  import qrs_pkg::*;
#(
  parameter int COEF_WIDTH = COEF_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  localparam int DW = 2 * COEF_WIDTH + 3,
  localparam int NW = COEF_WIDTH + FRAC_BITS + 2
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_vld,
  input  logic signed [COEF_WIDTH-1:0] a,
  input  logic signed [COEF_WIDTH-1:0] b,
  input  logic signed [COEF_WIDTH-1:0] c,
  output qrs_ctl_t                     ctl,
  output logic [DW-2:0]                mag,
  output logic signed [NW-1:0]         nb,
  output logic signed [COEF_WIDTH+1:0] den
);

  logic signed [2*COEF_WIDTH:0] bb, ac;
  logic signed [COEF_WIDTH-1:0] b1, a1;
  logic                         v1, az1;
  logic signed [DW-1:0]         d;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      ctl <= '0;
    end else begin
      v1       <= in_vld;
      ctl.vld  <= v1;
      ctl.kind <= az1 ? KIND_NONE : (d == '0) ? KIND_EQUAL :
                  d[DW-1] ? KIND_COMPLEX : KIND_REAL;
    end
  end

  always_ff @(posedge clk) begin
    bb  <= (2*COEF_WIDTH+1)'(b * b);
    ac  <= (2*COEF_WIDTH+1)'(a * c);
    b1  <= b;
    a1  <= a;
    az1 <= (a == '0);
    mag <= d[DW-1] ? (DW-1)'(-d) : d[DW-2:0];
    nb  <= -(NW'(b1) <<< FRAC_BITS);
    den <= (COEF_WIDTH+2)'(a1) <<< 1;
  end

  assign d = DW'(bb) - (DW'(ac) <<< 2);

endmodule

// File: hw/rtl/qrs_sqrt.sv
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined digit-by-digit square root, one result bit per stage.
// Side data rides along the stages.
// ----------------------------------------------------------------------------
module qrs_sqrt
  import qrs_pkg::*;
#(
  parameter int IW = 34,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int SW = 8,
  localparam int RW = (IW + 1) / 2 + FRAC_BITS,
  localparam int NS = RW
) (
  input  logic          clk,
  input  logic          rst,
  input  qrs_ctl_t      in_ctl,
  input  logic [IW-1:0] val,
  input  logic [SW-1:0] in_side,
  output qrs_ctl_t      out_ctl,
  output logic [RW-1:0] root,
  output logic [SW-1:0] out_side
);

  localparam int XW = 2 * RW;

  qrs_ctl_t      ctl  [NS+1];
  logic [XW-1:0] x    [NS+1];
  logic [RW-1:0] q    [NS+1];
  logic [RW+1:0] rem  [NS+1];
  logic [SW-1:0] side [NS+1];

  assign ctl[0]  = in_ctl;
  assign x[0]    = XW'(val) << (2 * FRAC_BITS);
  assign q[0]    = '0;
  assign rem[0]  = '0;
  assign side[0] = in_side;

  for (genvar i = 0; i < NS; i++) begin : g_st
    logic [RW+1:0] r2, trial;
    assign r2    = {rem[i][RW-1:0], x[i][XW-1 -: 2]};
    assign trial = {q[i], 2'b01};
    always_ff @(posedge clk) begin
      if (rst) ctl[i+1] <= '0;
      else ctl[i+1] <= ctl[i];
    end
    always_ff @(posedge clk) begin
      x[i+1]    <= x[i] << 2;
      side[i+1] <= side[i];
      if (r2 >= trial) begin
        rem[i+1] <= r2 - trial;
        q[i+1]   <= {q[i][RW-2:0], 1'b1};
      end else begin
        rem[i+1] <= r2;
        q[i+1]   <= {q[i][RW-2:0], 1'b0};
      end
    end
  end

  assign out_ctl  = ctl[NS];
  assign root     = q[NS];
  assign out_side = side[NS];

endmodule

// File: hw/rtl/qrs_div.sv
// ----------------------------------------------------------------------------
// qrs_div
// Pipelined restoring divider, one quotient bit per stage, signed inputs
// taken as magnitudes, truncating signed quotient out. Side data rides along.
// ----------------------------------------------------------------------------
module qrs_div
  import qrs_pkg::*;
#(
  parameter int NWD = 40,
  parameter int DWD = 18,
  parameter int SW  = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_vld,
  input  logic signed [NWD-1:0] num,
  input  logic signed [DWD-1:0] dvs,
  input  logic [SW-1:0]         in_side,
  output logic                  out_vld,
  output logic signed [NWD-1:0] quo,
  output logic [SW-1:0]         out_side
);

  logic          v   [NWD+2];
  logic [NWD-1:0] nq [NWD+2];
  logic [DWD-1:0] dm [NWD+2];
  logic [DWD:0]   r  [NWD+2];
  logic           sg [NWD+2];
  logic [SW-1:0]  sd [NWD+2];

  always_ff @(posedge clk) begin
    if (rst) v[0] <= 1'b0;
    else v[0] <= in_vld;
    nq[0] <= num[NWD-1] ? NWD'(-num) : num;
    dm[0] <= dvs[DWD-1] ? DWD'(-dvs) : dvs;
    r[0]  <= '0;
    sg[0] <= num[NWD-1] ^ dvs[DWD-1];
    sd[0] <= in_side;
  end

  for (genvar i = 0; i < NWD; i++) begin : g_st
    logic [DWD:0] t;
    assign t = {r[i][DWD-1:0], nq[i][NWD-1]};
    always_ff @(posedge clk) begin
      if (rst) v[i+1] <= 1'b0;
      else v[i+1] <= v[i];
    end
    always_ff @(posedge clk) begin
      dm[i+1] <= dm[i];
      sg[i+1] <= sg[i];
      sd[i+1] <= sd[i];
      if (t >= {1'b0, dm[i]}) begin
        r[i+1]  <= t - {1'b0, dm[i]};
        nq[i+1] <= {nq[i][NWD-2:0], 1'b1};
      end else begin
        r[i+1]  <= t;
        nq[i+1] <= {nq[i][NWD-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v[NWD+1] <= 1'b0;
    else v[NWD+1] <= v[NWD];
    nq[NWD+1] <= sg[NWD] ? NWD'(-nq[NWD]) : nq[NWD];
    sd[NWD+1] <= sd[NWD];
  end

  assign out_vld  = v[NWD+1];
  assign quo      = nq[NWD+1];
  assign out_side = sd[NWD+1];

endmodule

// File: hw/rtl/quadratic_root_solver_core.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver_core
// Roots of a*x^2 + b*x + c with exact discriminant and Q.FRAC_BITS outputs.
// ----------------------------------------------------------------------------
// Pipeline: the two-stage discriminant, the one-bit-per-stage root and the
//   one-bit-per-stage dividers, which run side by side.
// Throughput: one item per cycle; busy is tied low, results cannot be held off.
// Reset: synchronous rst clears every valid bit; data registers are unreset.
module quadratic_root_solver_core
  import qrs_pkg::*;
#(
  parameter int COEF_WIDTH = COEF_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COEF_WIDTH-1:0] coef_a,
  input  logic signed [COEF_WIDTH-1:0] coef_b,
  input  logic signed [COEF_WIDTH-1:0] coef_c,
  output logic                         done,
  output logic [1:0]                   root_kind,
  output logic signed [VAL_WIDTH-1:0]  first_value,
  output logic signed [VAL_WIDTH-1:0]  second_value
);

  localparam int DW  = 2 * COEF_WIDTH + 3;   // signed discriminant
  localparam int MW  = DW - 1;               // its magnitude
  localparam int RW  = (MW + 1) / 2 + FRAC_BITS;
  localparam int NW  = COEF_WIDTH + FRAC_BITS + 2;
  localparam int QW  = (RW > NW ? RW : NW) + 2; // numerator width
  localparam int CW  = COEF_WIDTH + 2;
  localparam int SSW = NW + CW + 2;
  localparam int QSW = QW + CW + 3;
  localparam int XW  = QW + VAL_WIDTH;        // saturation compare width

  localparam logic signed [XW-1:0] SAT_HI = XW'({1'b0, {(VAL_WIDTH-1){1'b1}}});
  localparam logic signed [XW-1:0] SAT_LO = -SAT_HI - XW'(1);

  qrs_ctl_t             d_ctl, s_ctl;
  logic [MW-1:0]        d_mag;
  logic signed [NW-1:0] d_nb, s_nb;
  logic signed [CW-1:0] d_den, s_den;
  logic [RW-1:0]        s_root;
  logic [SSW-1:0]       s_side;

  // Numerators for the two divider lanes, registered.
  logic                 n_vld;
  logic [1:0]           n_kind;
  logic signed [QW-1:0] n1, n2;
  logic signed [CW-1:0] n_den;

  logic                 q_vld;
  logic signed [QW-1:0] q1, q2;
  logic [1:0]           q_kind;
  logic [CW+2:0]        q_side;

  assign busy = 1'b0; // fully pipelined: a transfer every cycle

  qrs_disc #(.COEF_WIDTH(COEF_WIDTH), .FRAC_BITS(FRAC_BITS)) u_disc (
    .clk(clk), .rst(rst), .in_vld(start),
    .a(coef_a), .b(coef_b), .c(coef_c),
    .ctl(d_ctl), .mag(d_mag), .nb(d_nb), .den(d_den)
  );

  qrs_sqrt #(.IW(MW), .FRAC_BITS(FRAC_BITS), .SW(SSW)) u_sqrt (
    .clk(clk), .rst(rst), .in_ctl(d_ctl), .val(d_mag),
    .in_side({d_nb, d_den, 2'b00}),
    .out_ctl(s_ctl), .root(s_root), .out_side(s_side)
  );

  assign s_nb  = s_side[SSW-1 -: NW];
  assign s_den = s_side[CW+1:2];

  // Choose numerators per case: real roots use -b +/- s, complex -b and s, else -b twice.
  always_ff @(posedge clk) begin
    if (rst) n_vld <= 1'b0;
    else n_vld <= s_ctl.vld;
    n_kind <= s_ctl.kind;
    n_den  <= s_den;
    if (s_ctl.kind == KIND_REAL) begin
      n1 <= QW'(s_nb) + QW'(s_root);
      n2 <= QW'(s_nb) - QW'(s_root);
    end else begin
      n1 <= QW'(s_nb);
      n2 <= (s_ctl.kind == KIND_COMPLEX) ? QW'(s_root) : QW'(s_nb);
    end
  end

  // Both dividers share the same latency; valid and kind ride in lane one.
  logic            q2_vld;
  logic [CW+2:0]   q2_side;

  qrs_div #(.NWD(QW), .DWD(CW), .SW(CW+3)) u_div1 (
    .clk(clk), .rst(rst), .in_vld(n_vld), .num(n1), .dvs(n_den),
    .in_side({n_kind, (CW+1)'(0)}),
    .out_vld(q_vld), .quo(q1), .out_side(q_side)
  );

  qrs_div #(.NWD(QW), .DWD(CW), .SW(CW+3)) u_div2 (
    .clk(clk), .rst(rst), .in_vld(n_vld), .num(n2), .dvs(n_den),
    .in_side({n_kind, (CW+1)'(0)}),
    .out_vld(q2_vld), .quo(q2), .out_side(q2_side)
  );

  assign q_kind = q_side[CW+2:CW+1];

  // Saturate to the output range; a == 0 forces zero values.
  function automatic logic signed [VAL_WIDTH-1:0] sat(input logic signed [QW-1:0] x);
    logic signed [XW-1:0] xe;
    xe = XW'(x);
    if (xe > SAT_HI)
      return SAT_HI[VAL_WIDTH-1:0];
    if (xe < SAT_LO)
      return SAT_LO[VAL_WIDTH-1:0];
    return xe[VAL_WIDTH-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= q_vld;
    root_kind <= q_kind;
    if (q_kind == KIND_NONE) begin
      first_value  <= '0;
      second_value <= '0;
    end else begin
      first_value  <= sat(q1);
      second_value <= sat(q2);
    end
  end

  // The two divider lanes march in lockstep.
  a_lanes: assert property (@(posedge clk) disable iff (rst) q_vld == q2_vld)
    else $error("divider lanes out of step");
  a_side: assert property (@(posedge clk) disable iff (rst)
    q_vld |-> q_side == q2_side)
    else $error("divider side data mismatch");
  a_none: assert property (@(posedge clk) disable iff (rst)
    done && root_kind == KIND_NONE |-> first_value == '0 && second_value == '0)
    else $error("nonzero values for non-quadratic");
  a_idle: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

endmodule
